// ===== hdl/skf_pkg.sv =====
// shared types and constants of the scalar kalman filter
`default_nettype none

package skf_pkg;

  // width of the fixed-point covariance, variances and estimate
  localparam int unsigned VAL_W = 32;
  // width of the whole part in a result
  localparam int unsigned WHOLE_W = 16;
  // result tdata: estimate, then its whole part
  localparam int unsigned OUT_W = VAL_W + WHOLE_W;

  // configuration port
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_MEAS_VAR = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_PROC_VAR = 1'b1;

  // whole part of the default measurement variance
  localparam int unsigned MEAS_VAR_INIT_WHOLE = 160;

  typedef logic [VAL_W-1:0] val_t;

  // control from the stream side to the core
  typedef struct packed {
    logic start;
    logic take;
  } core_ctrl_t;

  // status from the core to the stream side
  typedef struct packed {
    logic idle;
    logic done;
  } core_stat_t;

endpackage

`default_nettype wire

// ===== hdl/scalar_kalman_filter.sv =====
// top level of the scalar kalman filter: stream ports, register port, result register
//
// Input stream (s_axis_*): one unsigned sample per item in the low SAMPLE_BITS
// bits of tdata. Output stream (m_axis_*): one result per sample, the new
// estimate in unsigned fixed point with FRAC_BITS fraction bits and its
// truncated whole part.
// Register port: register 0 at byte address 0 is the measurement variance,
// register 1 at byte address 4 the process variance, both unsigned fixed point.
// Write them only while no sample is in flight.
// After acceptance the core forms the predicted covariance, the gain
// denominator and the gain by division, then the new covariance and estimate,
// after which the result enters the output register and m_axis_tvalid goes high.
// A sample is taken only once the last one has left the core. The gain division
// works bit by bit; the two products go one after the other through one multiplier.
// s_axis_tready is high only while the core is idle.
// Reset sets the covariance to 1.0, the estimate to zero, and the variances to
// 160.0 and 1.0. If the receiver stalls, the result waits in the output register
// and the next sample is still taken and computed; that one then waits in the
// core until the output register frees up.
`default_nettype none

module scalar_kalman_filter #(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                                      clk_i,
  input  wire logic                                      rst_ni,
  // sample stream
  input  wire logic                                      s_axis_tvalid,
  output logic                                           s_axis_tready,
  // tdata: sample
  input  wire logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0]  s_axis_tdata,
  // result stream
  output logic                                           m_axis_tvalid,
  input  wire logic                                      m_axis_tready,
  // tdata: estimate, estimate_whole
  output logic [skf_pkg::OUT_W-1:0]                      m_axis_tdata,
  // register port
  input  wire logic                                      psel,
  input  wire logic                                      penable,
  input  wire logic                                      pwrite,
  input  wire logic [skf_pkg::ADDR_W-1:0]                paddr,
  input  wire logic [skf_pkg::VAL_W-1:0]                 pwdata,
  output logic [skf_pkg::VAL_W-1:0]                      prdata,
  output logic                                           pready
);

  localparam skf_pkg::val_t MEAS_INIT =
    skf_pkg::val_t'(64'(skf_pkg::MEAS_VAR_INIT_WHOLE) << FRAC_BITS);
  localparam skf_pkg::val_t PROC_INIT = skf_pkg::val_t'(64'd1 << FRAC_BITS);

  skf_pkg::val_t                  meas_var_q;
  skf_pkg::val_t                  proc_var_q;
  logic                           out_valid_q;
  skf_pkg::val_t                  out_est_q;
  logic [skf_pkg::WHOLE_W-1:0]    out_whole_q;

  logic [skf_pkg::REG_IDX_W-1:0]  reg_idx;
  logic                           reg_wr;
  skf_pkg::core_ctrl_t            core_ctrl;
  skf_pkg::core_stat_t            core_stat;
  skf_pkg::val_t                  core_est;
  skf_pkg::val_t                  est_shr;
  logic                           out_free;

  // register decode
  assign reg_idx = paddr[skf_pkg::ADDR_W-1:2];
  assign reg_wr  = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_comb begin
    case (reg_idx)
      skf_pkg::REG_MEAS_VAR: prdata = meas_var_q;
      skf_pkg::REG_PROC_VAR: prdata = proc_var_q;
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      meas_var_q <= MEAS_INIT;
      proc_var_q <= PROC_INIT;
    end else if (reg_wr) begin
      case (reg_idx)
        skf_pkg::REG_MEAS_VAR: meas_var_q <= pwdata;
        skf_pkg::REG_PROC_VAR: proc_var_q <= pwdata;
        default: begin
          meas_var_q <= meas_var_q;
        end
      endcase
    end
  end

  // handshake to the core
  assign s_axis_tready   = core_stat.idle;
  assign out_free        = ~out_valid_q | m_axis_tready;
  assign core_ctrl.start = s_axis_tvalid & core_stat.idle;
  assign core_ctrl.take  = core_stat.done & out_free;

  skf_core #(
    .FRAC_BITS   (FRAC_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (core_ctrl),
    .sample_i   (s_axis_tdata[SAMPLE_BITS-1:0]),
    .meas_var_i (meas_var_q),
    .proc_var_i (proc_var_q),
    .stat_o     (core_stat),
    .estimate_o (core_est)
  );

  // output register
  assign est_shr = core_est >> FRAC_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (core_ctrl.take) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_ctrl.take) begin
      out_est_q   <= core_est;
      out_whole_q <= est_shr[skf_pkg::WHOLE_W-1:0];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_whole_q, out_est_q};

endmodule

`default_nettype wire

// ===== hdl/skf_div.sv =====
// iterative restoring divider for the gain, one quotient bit per cycle
`default_nettype none

module skf_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   start_i,
  input  wire skf_pkg::val_t          num_i,
  input  wire skf_pkg::val_t          den_i,
  output logic                        done_o,
  output logic [FRAC_BITS:0]          quot_o
);

  localparam int unsigned GW    = FRAC_BITS + 1;
  localparam int unsigned CNT_W = $clog2(FRAC_BITS + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic                  zero_q, zero_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  skf_pkg::val_t         rem_q, rem_d;
  skf_pkg::val_t         den_q, den_d;
  logic [GW-1:0]         quot_q, quot_d;

  logic [skf_pkg::VAL_W:0] rem_sh;
  logic [skf_pkg::VAL_W:0] rem_sub;
  logic                    step_bit;
  logic                    first_bit;

  // shared compare and subtract for one quotient bit
  always_comb begin
    rem_sh    = {rem_q, 1'b0};
    rem_sub   = rem_sh - {1'b0, den_q};
    step_bit  = (rem_sh >= {1'b0, den_q});
    first_bit = (num_i >= den_i);
  end

  // sequencing of the division steps
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    zero_d = zero_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quot_d = quot_q;
    if (start_i) begin
      // numerator never exceeds the denominator: top quotient bit first
      busy_d = 1'b1;
      zero_d = (den_i == '0);
      cnt_d  = CNT_W'(FRAC_BITS);
      den_d  = den_i;
      rem_d  = first_bit ? (num_i - den_i) : num_i;
      quot_d = {{(GW-1){1'b0}}, first_bit};
    end else if (busy_q) begin
      rem_d  = step_bit ? rem_sub[skf_pkg::VAL_W-1:0] : rem_sh[skf_pkg::VAL_W-1:0];
      quot_d = {quot_q[GW-2:0], step_bit};
      cnt_d  = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      zero_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      zero_q <= zero_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    den_q  <= den_d;
    quot_q <= quot_d;
  end

  // a zero denominator gives a zero gain
  assign done_o = done_q;
  assign quot_o = zero_q ? '0 : quot_q;

endmodule

`default_nettype wire

// ===== hdl/skf_core.sv =====
// filter sequencer with state, saturating adds and one shared multiplier
`default_nettype none

module skf_core #(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire skf_pkg::core_ctrl_t    ctrl_i,
  input  wire logic [SAMPLE_BITS-1:0] sample_i,
  input  wire skf_pkg::val_t          meas_var_i,
  input  wire skf_pkg::val_t          proc_var_i,
  output skf_pkg::core_stat_t         stat_o,
  output skf_pkg::val_t               estimate_o
);

  localparam int unsigned VW = skf_pkg::VAL_W;
  localparam int unsigned GW = FRAC_BITS + 1;
  localparam int unsigned MW = GW + VW;
  localparam logic [GW-1:0] GAIN_ONE = {1'b1, {FRAC_BITS{1'b0}}};
  localparam skf_pkg::val_t P_INIT = skf_pkg::val_t'(64'd1 << FRAC_BITS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PC,
    S_DEN,
    S_DIV,
    S_MULP,
    S_UPDP,
    S_UPDE,
    S_DONE
  } state_e;

  state_e         state_q;
  skf_pkg::val_t  cov_q;
  skf_pkg::val_t  est_q;
  skf_pkg::val_t  sval_q;
  skf_pkg::val_t  pc_q;
  logic [GW-1:0]  gain_q;
  logic [MW-1:0]  prod_q;

  logic [63:0]     sval_ext;
  skf_pkg::val_t   sval_sat;
  logic [VW:0]     pc_sum;
  skf_pkg::val_t   pc_sat;
  logic [VW:0]     den_sum;
  skf_pkg::val_t   den_sat;
  logic            at_or_above;
  skf_pkg::val_t   diff;
  logic [GW-1:0]   mul_a;
  skf_pkg::val_t   mul_b;
  logic [MW-1:0]   mul_p;
  skf_pkg::val_t   prod_shr;
  logic            div_start;
  logic            div_done;
  logic [GW-1:0]   div_quot;

  // sample scaled to fixed point, clipped at the register maximum
  always_comb begin
    sval_ext = 64'(sample_i) << FRAC_BITS;
    sval_sat = (sval_ext[63:VW] != '0) ? '1 : sval_ext[VW-1:0];
  end

  // saturating sums for the predicted covariance and the gain denominator
  always_comb begin
    pc_sum  = {1'b0, cov_q} + {1'b0, proc_var_i};
    pc_sat  = pc_sum[VW] ? '1 : pc_sum[VW-1:0];
    den_sum = {1'b0, pc_q} + {1'b0, meas_var_i};
    den_sat = den_sum[VW] ? '1 : den_sum[VW-1:0];
  end

  // innovation magnitude and direction
  always_comb begin
    at_or_above = (sval_q >= est_q);
    diff        = at_or_above ? (sval_q - est_q) : (est_q - sval_q);
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MULP: begin
        mul_a = GAIN_ONE - gain_q;
        mul_b = pc_q;
      end
      S_UPDP: begin
        mul_a = gain_q;
        mul_b = diff;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p    = MW'(mul_a) * MW'(mul_b);
    prod_shr = prod_q[FRAC_BITS +: VW];
  end

  assign div_start = (state_q == S_DEN);

  skf_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (pc_q),
    .den_i   (den_sat),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // sequencer, filter state and working registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cov_q   <= P_INIT;
      est_q   <= '0;
      sval_q  <= '0;
      pc_q    <= '0;
      gain_q  <= '0;
      prod_q  <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (ctrl_i.start) begin
            sval_q  <= sval_sat;
            state_q <= S_PC;
          end
        end
        S_PC: begin
          pc_q    <= pc_sat;
          state_q <= S_DEN;
        end
        S_DEN: begin
          state_q <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            gain_q  <= div_quot;
            state_q <= S_MULP;
          end
        end
        S_MULP: begin
          // (1 - gain) * predicted covariance
          prod_q  <= mul_p;
          state_q <= S_UPDP;
        end
        S_UPDP: begin
          // gain * innovation
          cov_q   <= prod_shr;
          prod_q  <= mul_p;
          state_q <= S_UPDE;
        end
        S_UPDE: begin
          est_q   <= at_or_above ? (est_q + prod_shr) : (est_q - prod_shr);
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (ctrl_i.take) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign stat_o.idle = (state_q == S_IDLE);
  assign stat_o.done = (state_q == S_DONE);
  assign estimate_o  = est_q;

endmodule

`default_nettype wire
